@@ src/buffer_chunk_swap_engine_top_defines.svh @@
// Assertion macros for the buffer chunk swap engine RTL.
`ifndef BUFFER_CHUNK_SWAP_ENGINE_TOP_DEFINES_SVH
`define BUFFER_CHUNK_SWAP_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BCSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcse check failed");
`define BCSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcse check failed");
`else
`define BCSE_ASSERT_IMP(lbl, ante, cons)
`define BCSE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ src/bcse_pkg.sv @@
// Types, codes and constants of the buffer chunk swap engine.
package bcse_pkg;

  localparam int unsigned DEPTH_DEF        = 4096;
  localparam int unsigned MAX_CHANNELS_DEF = 8;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CH_W     = 4;
  localparam int unsigned FRAMES_W = 13;
  localparam int unsigned START_W  = 13;
  localparam int unsigned LEN_W    = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;
  // signed frame arithmetic: holds start + count with room for the sign
  localparam int unsigned FA_W = 16;
  localparam int unsigned PROD_W = CH_W + FRAMES_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_SWAP = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_SRC_START = 3'd1,
    STAT_SRC_END   = 3'd2,
    STAT_DST_START = 3'd3,
    STAT_DST_END   = 3'd4,
    STAT_BAD       = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 3'd0,
    CFG_FRAME_COUNT   = 3'd1,
    CFG_SOURCE_START  = 3'd2,
    CFG_DEST_START    = 3'd3,
    CFG_SWAP_LENGTH   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_GEOM,
    S_RANGE,
    S_SWAP_RD,
    S_SWAP_WR_D,
    S_SWAP_WR_S,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [CH_W-1:0]            channel_count;
    logic [FRAMES_W-1:0]        frame_count;
    logic signed [START_W-1:0]  source_start;
    logic signed [START_W-1:0]  dest_start;
    logic signed [LEN_W-1:0]    swap_length;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    status_e           status;
  } res_t;

endpackage

@@ src/buffer_chunk_swap_engine_top.sv @@
// Buffer chunk swap engine: config registers, output register, store and sequencer.
// Load: result registered at the accept edge; requests taken while the output has room.
// Read: accept, then RD_WAIT for the registered read port of the store; holds until taken.
// Swap: accept, GEOM and RANGE checks (on failure to RESULT), then channel_count * |count|
//   word pairs (read both, write each on the single write port), then RESULT.
// Reset clears control and config to defaults; the sample store is not cleared.
module buffer_chunk_swap_engine_top #(
  parameter int unsigned DEPTH        = bcse_pkg::DEPTH_DEF,
  parameter int unsigned MAX_CHANNELS = bcse_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bcse_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bcse_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // command[1:0], word_address[13:2], sample_word[45:14], zero[47:46]
  input  logic [bcse_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // read_word[31:0], status[34:32], zero[39:35]
  output logic [bcse_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned AW = $clog2(DEPTH);

  bcse_pkg::cfg_t cfg_q, cfg_d;
  bcse_pkg::res_t res, out_res_q, out_res_d;
  logic           res_valid, res_ready;
  logic           out_valid_q, out_valid_d;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [bcse_pkg::WORD_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bcse_pkg::CFG_CHANNEL_COUNT:
          cfg_d.channel_count = cfg_wdata_i[bcse_pkg::CH_W-1:0];
        bcse_pkg::CFG_FRAME_COUNT:
          cfg_d.frame_count = cfg_wdata_i[bcse_pkg::FRAMES_W-1:0];
        bcse_pkg::CFG_SOURCE_START:
          cfg_d.source_start = $signed(cfg_wdata_i[bcse_pkg::START_W-1:0]);
        bcse_pkg::CFG_DEST_START:
          cfg_d.dest_start = $signed(cfg_wdata_i[bcse_pkg::START_W-1:0]);
        bcse_pkg::CFG_SWAP_LENGTH:
          cfg_d.swap_length = $signed(cfg_wdata_i[bcse_pkg::LEN_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= bcse_pkg::CH_W'(1);
      cfg_q.frame_count   <= bcse_pkg::FRAMES_W'(4096);
      cfg_q.source_start  <= '0;
      cfg_q.dest_start    <= '1;
      cfg_q.swap_length   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // output register: takes a new result when empty or when the old one leaves this cycle
  assign res_ready   = !out_valid_q || m_axis_tready;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && !m_axis_tready);
  assign out_res_d   = (res_valid && res_ready) ? res : out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_res_q.status, out_res_q.read_word};

  bcse_ctrl #(
    .DEPTH        (DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (s_axis_tdata[1:0]),
    .in_addr_i     (s_axis_tdata[13:2]),
    .in_word_i     (s_axis_tdata[45:14]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  bcse_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

endmodule

@@ src/bcse_mem.sv @@
// Sample store: one write port, two registered read ports.
module bcse_mem #(
  parameter int unsigned DEPTH = bcse_pkg::DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [bcse_pkg::WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_a_i,
  input  logic [AW-1:0]               raddr_b_i,
  output logic [bcse_pkg::WORD_W-1:0] rdata_a_o,
  output logic [bcse_pkg::WORD_W-1:0] rdata_b_o
);

  logic [bcse_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [bcse_pkg::WORD_W-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ src/bcse_ctrl.sv @@
// Command sequencer: word access, swap checks and the read-swap-write walk.
`include "buffer_chunk_swap_engine_top_defines.svh"

module bcse_ctrl #(
  parameter int unsigned DEPTH        = bcse_pkg::DEPTH_DEF,
  parameter int unsigned MAX_CHANNELS = bcse_pkg::MAX_CHANNELS_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bcse_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bcse_pkg::CMD_W-1:0]    in_cmd_i,
  input  logic [bcse_pkg::ADDR_W-1:0]   in_addr_i,
  input  logic [bcse_pkg::WORD_W-1:0]   in_word_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output bcse_pkg::res_t                res_o,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [bcse_pkg::WORD_W-1:0]   mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_a_o,
  output logic [AW-1:0]                 mem_raddr_b_o,
  input  logic [bcse_pkg::WORD_W-1:0]   mem_rdata_a_i,
  input  logic [bcse_pkg::WORD_W-1:0]   mem_rdata_b_i
);

  localparam int unsigned FA_W = bcse_pkg::FA_W;

  function automatic logic out_of_range(input logic signed [FA_W-1:0] f,
                                        input logic signed [FA_W-1:0] lim);
    return (f < 0) || (f >= lim);
  endfunction

  bcse_pkg::state_e state_q, state_d;

  logic [AW-1:0]                 rd_addr_q, rd_addr_d;
  bcse_pkg::status_e             res_status_q, res_status_d;
  logic signed [FA_W-1:0]        src_q, src_d, src_stop_q, src_stop_d;
  logic signed [FA_W-1:0]        dst_q, dst_d, dst_stop_q, dst_stop_d;
  logic                          neg_q, neg_d;
  logic [bcse_pkg::LEN_W-1:0]    mag_q, mag_d;
  logic [bcse_pkg::LEN_W-1:0]    left_q, left_d;
  logic [bcse_pkg::CH_W-1:0]     chan_q, chan_d;
  logic [AW-1:0]                 sa_q, sa_d, da_q, da_d;
  logic [bcse_pkg::WORD_W-1:0]   tmp_q, tmp_d;

  logic                          accept, addr_ok;
  logic [bcse_pkg::PROD_W-1:0]   prod, sa_init, da_init;
  logic                          geom_bad;
  logic signed [FA_W-1:0]        frames_s, dst_eff, cnt_eff, mag_eff;
  logic [bcse_pkg::FRAMES_W-2:0] half;
  bcse_pkg::status_e             chk_status;
  logic                          last_chan, last_pair;
  logic [AW-1:0]                 back_step;

  assign accept  = in_valid_i && in_ready_o;
  assign addr_ok = 32'(in_addr_i) < DEPTH;

  // geometry and defaults
  assign prod     = bcse_pkg::PROD_W'(cfg_i.channel_count) *
                    bcse_pkg::PROD_W'(cfg_i.frame_count);
  assign geom_bad = (cfg_i.channel_count == '0) ||
                    (32'(cfg_i.channel_count) > MAX_CHANNELS) ||
                    (cfg_i.frame_count == '0) || (32'(prod) > DEPTH);
  assign frames_s = $signed(FA_W'(cfg_i.frame_count));
  assign half     = cfg_i.frame_count[bcse_pkg::FRAMES_W-1:1];
  assign dst_eff  = (cfg_i.dest_start == -13'sd1) ? frames_s - 16'sd1
                                                  : FA_W'(cfg_i.dest_start);
  assign cnt_eff  = (cfg_i.swap_length == '0) ? -$signed({4'd0, half})
                                              : FA_W'(cfg_i.swap_length);
  assign mag_eff  = cnt_eff[FA_W-1] ? -cnt_eff : cnt_eff;

  always_comb begin
    if (out_of_range(src_q, frames_s)) begin
      chk_status = bcse_pkg::STAT_SRC_START;
    end else if (out_of_range(src_stop_q, frames_s)) begin
      chk_status = bcse_pkg::STAT_SRC_END;
    end else if (out_of_range(dst_q, frames_s)) begin
      chk_status = bcse_pkg::STAT_DST_START;
    end else if (out_of_range(dst_stop_q, frames_s)) begin
      chk_status = bcse_pkg::STAT_DST_END;
    end else begin
      chk_status = bcse_pkg::STAT_OK;
    end
  end

  // start words of the first frame pair; only used once both ranges passed
  assign sa_init = bcse_pkg::PROD_W'(src_q[bcse_pkg::FRAMES_W-1:0]) *
                   bcse_pkg::PROD_W'(cfg_i.channel_count);
  assign da_init = bcse_pkg::PROD_W'(dst_q[bcse_pkg::FRAMES_W-1:0]) *
                   bcse_pkg::PROD_W'(cfg_i.channel_count);

  assign last_chan = chan_q == (cfg_i.channel_count - 4'd1);
  assign last_pair = last_chan && (left_q == bcse_pkg::LEN_W'(1));
  // backward walk: from the last channel of a frame to channel 0 of the one before
  assign back_step = AW'({cfg_i.channel_count, 1'b0}) - AW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcse_pkg::S_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            bcse_pkg::CMD_SWAP: state_d = bcse_pkg::S_GEOM;
            bcse_pkg::CMD_READ: state_d = addr_ok ? bcse_pkg::S_RD_WAIT : bcse_pkg::S_IDLE;
            default:            state_d = bcse_pkg::S_IDLE;
          endcase
        end
      end
      bcse_pkg::S_RD_WAIT: if (res_ready_i) state_d = bcse_pkg::S_IDLE;
      bcse_pkg::S_GEOM:    state_d = geom_bad ? bcse_pkg::S_RESULT : bcse_pkg::S_RANGE;
      bcse_pkg::S_RANGE: begin
        state_d = (chk_status == bcse_pkg::STAT_OK) ? bcse_pkg::S_SWAP_RD
                                                    : bcse_pkg::S_RESULT;
      end
      bcse_pkg::S_SWAP_RD:   state_d = bcse_pkg::S_SWAP_WR_D;
      bcse_pkg::S_SWAP_WR_D: state_d = bcse_pkg::S_SWAP_WR_S;
      bcse_pkg::S_SWAP_WR_S: state_d = last_pair ? bcse_pkg::S_RESULT : bcse_pkg::S_SWAP_RD;
      bcse_pkg::S_RESULT:    if (res_ready_i) state_d = bcse_pkg::S_IDLE;
      default:               state_d = bcse_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    res_valid_o     = 1'b0;
    res_o.read_word = '0;
    res_o.status    = bcse_pkg::STAT_OK;
    mem_we_o        = 1'b0;
    mem_waddr_o     = da_q;
    mem_wdata_o     = mem_rdata_b_i;
    mem_raddr_a_o   = da_q;
    mem_raddr_b_o   = sa_q;
    unique case (state_q)
      bcse_pkg::S_IDLE: begin
        in_ready_o    = res_ready_i;
        mem_raddr_a_o = AW'(in_addr_i);
        mem_waddr_o   = AW'(in_addr_i);
        mem_wdata_o   = in_word_i;
        mem_we_o      = accept && (in_cmd_i == bcse_pkg::CMD_LOAD) && addr_ok;
        res_valid_o   = accept && (in_cmd_i != bcse_pkg::CMD_SWAP) &&
                        !((in_cmd_i == bcse_pkg::CMD_READ) && addr_ok);
        res_o.status  = ((in_cmd_i == bcse_pkg::CMD_LOAD) && addr_ok) ?
                        bcse_pkg::STAT_OK : bcse_pkg::STAT_BAD;
      end
      bcse_pkg::S_RD_WAIT: begin
        mem_raddr_a_o   = rd_addr_q;
        res_valid_o     = 1'b1;
        res_o.read_word = mem_rdata_a_i;
      end
      bcse_pkg::S_SWAP_WR_D: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = da_q;
        mem_wdata_o = mem_rdata_b_i;
      end
      bcse_pkg::S_SWAP_WR_S: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = sa_q;
        mem_wdata_o = tmp_q;
      end
      bcse_pkg::S_RESULT: begin
        res_valid_o  = 1'b1;
        res_o.status = res_status_q;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    rd_addr_d    = rd_addr_q;
    res_status_d = res_status_q;
    src_d        = src_q;
    src_stop_d   = src_stop_q;
    dst_d        = dst_q;
    dst_stop_d   = dst_stop_q;
    neg_d        = neg_q;
    mag_d        = mag_q;
    left_d       = left_q;
    chan_d       = chan_q;
    sa_d         = sa_q;
    da_d         = da_q;
    tmp_d        = tmp_q;
    case (state_q)
      bcse_pkg::S_IDLE: rd_addr_d = AW'(in_addr_i);
      bcse_pkg::S_GEOM: begin
        res_status_d = bcse_pkg::STAT_BAD;
        src_d        = FA_W'(cfg_i.source_start);
        dst_d        = dst_eff;
        neg_d        = cnt_eff[FA_W-1];
        mag_d        = mag_eff[bcse_pkg::LEN_W-1:0];
        src_stop_d   = FA_W'(cfg_i.source_start) + mag_eff - 16'sd1;
        dst_stop_d   = cnt_eff[FA_W-1] ? dst_eff + cnt_eff + 16'sd1
                                       : dst_eff + cnt_eff - 16'sd1;
      end
      bcse_pkg::S_RANGE: begin
        res_status_d = chk_status;
        sa_d         = AW'(sa_init);
        da_d         = AW'(da_init);
        chan_d       = '0;
        left_d       = mag_q;
      end
      bcse_pkg::S_SWAP_WR_D: tmp_d = mem_rdata_a_i;
      bcse_pkg::S_SWAP_WR_S: begin
        res_status_d = bcse_pkg::STAT_OK;
        sa_d         = sa_q + AW'(1);
        if (last_chan) begin
          chan_d = '0;
          left_d = left_q - bcse_pkg::LEN_W'(1);
          da_d   = neg_q ? da_q - back_step : da_q + AW'(1);
        end else begin
          chan_d = chan_q + 4'd1;
          da_d   = da_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcse_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q    <= rd_addr_d;
    res_status_q <= res_status_d;
    src_q        <= src_d;
    src_stop_q   <= src_stop_d;
    dst_q        <= dst_d;
    dst_stop_q   <= dst_stop_d;
    neg_q        <= neg_d;
    mag_q        <= mag_d;
    left_q       <= left_d;
    chan_q       <= chan_d;
    sa_q         <= sa_d;
    da_q         <= da_d;
    tmp_q        <= tmp_d;
  end

  `BCSE_ASSERT_IMP(a_we_in_write_state, mem_we_o, (state_q == bcse_pkg::S_IDLE) || (state_q == bcse_pkg::S_SWAP_WR_D) || (state_q == bcse_pkg::S_SWAP_WR_S))
  `BCSE_ASSERT_NXT(a_swap_goes_to_check, accept && (in_cmd_i == bcse_pkg::CMD_SWAP), state_q == bcse_pkg::S_GEOM)
  `BCSE_ASSERT_IMP(a_chan_in_frame, (state_q == bcse_pkg::S_SWAP_RD) || (state_q == bcse_pkg::S_SWAP_WR_D) || (state_q == bcse_pkg::S_SWAP_WR_S), chan_q < cfg_i.channel_count)
  `BCSE_ASSERT_IMP(a_walk_ends_ok, (state_q == bcse_pkg::S_RESULT) && ($past(state_q) == bcse_pkg::S_SWAP_WR_S), res_o.status == bcse_pkg::STAT_OK)
  `BCSE_ASSERT_IMP(a_idle_result_fits, res_valid_o && (state_q == bcse_pkg::S_IDLE), res_ready_i)

endmodule
